// ===== design/fircirc_pkg.sv =====
// Shared types and constants for the circular-line FIR filter.
package fircirc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int MAX_TAPS  = 8;
    localparam int SUM_W     = PROD_W + $clog2(MAX_TAPS);
    localparam int FRAC_W    = 15;
    localparam int QUOT_W    = SUM_W + 1 - FRAC_W;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [SUM_W-1:0]    t_sum;

    // Partial sum that travels down the cell chain with its token
    typedef struct packed {
        logic tok;
        t_sum sum;
    } t_part;

    // Half of one output LSB, added before the shift for round-to-nearest
    localparam logic signed [SUM_W:0] ROUND_HALF = (SUM_W + 1)'(1) <<< (FRAC_W - 1);

endpackage

// ===== design/fir_filter_circular_core.sv =====
// Top level of the circular-line FIR filter: coefficient registers, tap chain, rounding, output.
//
// Usage
//   Input channel: i_valid / i_sample, with o_stall driven by the filter. A transfer takes
//   place at a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / o_filtered / o_clipped, with i_stall from the receiver.
//   Coefficients coef_0 (oldest sample) .. coef_(TAPS-1) (newest) are written through
//   i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while the filter is idle,
//   which the block does not enforce; indexes at or above TAPS are dropped.
//   The input transfer reaches o_valid through r_go1, r_go2, the tap cells in turn, the rounding
//   stage and the output register. The partial sum walks the tap cells one cell per cycle, and
//   o_stall stays high until the result has left the rounding stage; no new sample is taken before.
//   A finished result may wait in the output register while the next sample is taken.
//   When the receiver stalls, the result holds in the output register, a second one waits
//   in the rounding stage, and o_stall stays high until the output register frees.
//   Reset (synchronous, active low) clears the delay line and the coefficients to zero
//   and empties all stages.
module fir_filter_circular_core #(
    parameter int TAPS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [fircirc_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [fircirc_pkg::SAMPLE_W-1:0] o_filtered,
    output logic                                  o_clipped,
    input  logic                                  i_cfg_we,
    input  logic [fircirc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fircirc_pkg::COEF_W-1:0]        i_cfg_data
);

    fircirc_pkg::t_coef   r_coef [TAPS];
    fircirc_pkg::t_sample w_smp  [TAPS];
    fircirc_pkg::t_part   w_part [TAPS+1];

    logic r_busy;
    logic r_go1;
    logic r_go2;
    logic r_rnd_valid;
    logic r_out_valid;
    logic w_in_xfer;
    logic w_move;

    fircirc_pkg::t_sample r_rnd_val;
    logic                 r_rnd_clip;
    fircirc_pkg::t_sample r_out_val;
    logic                 r_out_clip;

    logic signed [fircirc_pkg::SUM_W:0]    w_biased;
    logic signed [fircirc_pkg::QUOT_W-1:0] w_quot;
    logic                                  w_ovf;
    fircirc_pkg::t_sample                  w_sat;

    assign w_in_xfer = i_valid && !r_busy;
    assign w_move    = r_rnd_valid && (!r_out_valid || !i_stall);

    // Hold the coefficient registers
    for (genvar k = 0; k < TAPS; k++) begin : g_coef
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_coef[k] <= '0;
            end else if (i_cfg_we && i_cfg_idx == fircirc_pkg::CFG_IDX_W'(k)) begin
                r_coef[k] <= i_cfg_data;
            end
        end
    end

    // Start the sum token through r_go1 and r_go2 after the transfer, once products reflect the new line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go1 <= 1'b0;
            r_go2 <= 1'b0;
        end else begin
            r_go1 <= w_in_xfer;
            r_go2 <= r_go1;
        end
    end

    assign w_part[0].tok = r_go2;
    assign w_part[0].sum = '0;

    // Chain of tap cells, oldest sample in cell 0
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        fircirc_pkg::t_sample w_cell_in;
        if (k == TAPS - 1) begin : g_last
            assign w_cell_in = i_sample;
        end else begin : g_mid
            assign w_cell_in = w_smp[k+1];
        end

        fircirc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_in_xfer),
            .i_sample (w_cell_in),
            .i_coef   (r_coef[k]),
            .i_part   (w_part[k]),
            .o_sample (w_smp[k]),
            .o_part   (w_part[k+1])
        );
    end

    // Round to nearest, drop the fraction and saturate to the sample width
    assign w_biased = {w_part[TAPS].sum[fircirc_pkg::SUM_W-1], w_part[TAPS].sum}
                    + fircirc_pkg::ROUND_HALF;
    assign w_quot   = w_biased[fircirc_pkg::SUM_W:fircirc_pkg::FRAC_W];
    assign w_ovf    = (w_quot[fircirc_pkg::QUOT_W-1:fircirc_pkg::SAMPLE_W-1] != '0)
                   && (w_quot[fircirc_pkg::QUOT_W-1:fircirc_pkg::SAMPLE_W-1] != '1);

    always_comb begin
        if (!w_ovf) begin
            w_sat = w_quot[fircirc_pkg::SAMPLE_W-1:0];
        end else if (w_quot[fircirc_pkg::QUOT_W-1]) begin
            w_sat = {1'b1, {(fircirc_pkg::SAMPLE_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(fircirc_pkg::SAMPLE_W-1){1'b1}}};
        end
    end

    // Rounding stage: catch the token at the end of the chain, hold until the output frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_valid <= 1'b0;
        end else if (w_part[TAPS].tok) begin
            r_rnd_valid <= 1'b1;
        end else if (w_move) begin
            r_rnd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_part[TAPS].tok) begin
            r_rnd_val  <= w_sat;
            r_rnd_clip <= w_ovf;
        end
    end

    // Output register: load from the rounding stage, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_val  <= r_rnd_val;
            r_out_clip <= r_rnd_clip;
        end
    end

    // Busy from the input transfer until the result leaves the rounding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_in_xfer) begin
            r_busy <= 1'b1;
        end else if (w_move) begin
            r_busy <= 1'b0;
        end
    end

    assign o_stall    = r_busy;
    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_val;
    assign o_clipped  = r_out_clip;

endmodule

// ===== design/fircirc_cell.sv =====
// One tap cell: a stored sample, its registered product and one step of the sum chain.
module fircirc_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  fircirc_pkg::t_sample   i_sample,
    input  fircirc_pkg::t_coef     i_coef,
    input  fircirc_pkg::t_part     i_part,
    output fircirc_pkg::t_sample   o_sample,
    output fircirc_pkg::t_part     o_part
);

    fircirc_pkg::t_sample r_smp;
    fircirc_pkg::t_prod   r_prod;
    logic                 r_tok;
    fircirc_pkg::t_sum    r_sum;
    fircirc_pkg::t_sum    n_sum;

    // Advance the delay line on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp <= '0;
        end else if (i_shift) begin
            r_smp <= i_sample;
        end
    end

    // Weight the stored sample every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * r_smp;
    end

    // Add this tap's product to the passing partial sum
    assign n_sum = i_part.sum + fircirc_pkg::SUM_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_part.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_part.tok) begin
            r_sum <= n_sum;
        end
    end

    assign o_sample = r_smp;
    assign o_part   = {r_tok, r_sum};

endmodule

// ===== design/fircirc_chk.sv =====
// Port-level checker for the FIR filter and its bind to the top level.
module fircirc_chk (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_stall,
    input logic                                   o_valid,
    input logic                                   i_stall,
    input logic signed [fircirc_pkg::SAMPLE_W-1:0] o_filtered,
    input logic                                   o_clipped
);

    // A waiting result holds while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_filtered) && $stable(o_clipped))
        else $error("output changed while stalled");

    // One sample at a time: the filter stalls right after an input transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after a transfer");

    // A clipped result sits at one of the two rails
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |->
            (o_filtered == 16'sh7fff || o_filtered == 16'sh8000))
        else $error("clipped result not at a rail");

    // Reset empties the filter
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("filter not empty after reset");

    // A result never appears the cycle after an input transfer
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("result appeared too early");

endmodule

bind fir_filter_circular_core fircirc_chk u_fircirc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_filtered (o_filtered),
    .o_clipped  (o_clipped)
);
